[src/wsu_pkg.sv]
`default_nettype none

package wsu_pkg;

    // Default width of the kept frame length
    localparam int unsigned LENGTH_BITS_DEF = 32;

    // First header byte of an accepted frame: FIN set, text or binary opcode
    localparam logic [7:0] HDR_TEXT   = 8'h81;
    localparam logic [7:0] HDR_BINARY = 8'h82;

    // Length codes in the second header byte
    localparam logic [6:0] LEN_CODE_MASK  = 7'h7f;
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Header byte counter end values (count before increment)
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] MASK_LAST  = 3'd3;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b000_0001,
        PH_LEN     = 7'b000_0010,
        PH_EXT16   = 7'b000_0100,
        PH_EXT64   = 7'b000_1000,
        PH_MASK    = 7'b001_0000,
        PH_PAYLOAD = 7'b010_0000,
        PH_DISCARD = 7'b100_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_binary;
        logic       frame_last;
    } t_out_word;

    // Status between the parser and the output register
    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_result;

endpackage : wsu_pkg

`default_nettype wire

[src/wsu_parser.sv]
`default_nettype none

module wsu_parser
    import wsu_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_word i_word,
    output t_result       o_res
);

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_hcnt, n_hcnt;
    logic [LENGTH_BITS-1:0] r_remain, n_remain;   // length, then bytes still to come
    logic [1:0]             r_key_sel, n_key_sel;
    logic [31:0]            r_mask_key, n_mask_key;
    logic                   r_binary, n_binary;

    logic [7:0] key_byte;
    logic [6:0] len_code;

    assign len_code = i_word.rx_byte[6:0] & LEN_CODE_MASK;

    always_comb begin
        unique case (r_key_sel)
            2'd0: key_byte = r_mask_key[31:24];
            2'd1: key_byte = r_mask_key[23:16];
            2'd2: key_byte = r_mask_key[15:8];
            2'd3: key_byte = r_mask_key[7:0];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    always_comb begin
        o_res.valid             = i_step && (r_phase == PH_PAYLOAD);
        o_res.word.payload_byte = i_word.rx_byte ^ key_byte;
        o_res.word.is_binary    = r_binary;
        o_res.word.frame_last   = (r_remain == LENGTH_BITS'(1));
    end

    always_comb begin
        n_phase    = r_phase;
        n_hcnt     = r_hcnt;
        n_remain   = r_remain;
        n_key_sel  = r_key_sel;
        n_mask_key = r_mask_key;
        n_binary   = r_binary;
        if (i_step) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_word.rx_byte == HDR_TEXT || i_word.rx_byte == HDR_BINARY) begin
                        n_binary = (i_word.rx_byte == HDR_BINARY);
                        n_phase  = PH_LEN;
                    end else begin
                        n_phase = PH_DISCARD;
                    end
                end
                PH_LEN: begin
                    n_hcnt     = 3'd0;
                    n_mask_key = 32'd0;
                    n_key_sel  = 2'd0;
                    if (len_code == LEN_CODE_EXT16) begin
                        n_remain = '0;
                        n_phase  = PH_EXT16;
                    end else if (len_code == LEN_CODE_EXT64) begin
                        n_remain = '0;
                        n_phase  = PH_EXT64;
                    end else begin
                        n_remain = LENGTH_BITS'(len_code);
                        n_phase  = PH_MASK;
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    // shift the length in, keeping only the low bits
                    n_remain = {r_remain[LENGTH_BITS-9:0], i_word.rx_byte};
                    n_hcnt   = r_hcnt + 3'd1;
                    if ((r_phase == PH_EXT16 && r_hcnt == EXT16_LAST) ||
                        (r_phase == PH_EXT64 && r_hcnt == EXT64_LAST)) begin
                        n_hcnt  = 3'd0;
                        n_phase = PH_MASK;
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_word.rx_byte};
                    n_hcnt     = r_hcnt + 3'd1;
                    if (r_hcnt == MASK_LAST) begin
                        n_hcnt    = 3'd0;
                        n_key_sel = 2'd0;
                        n_phase   = (r_remain == '0) ? PH_DISCARD : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_key_sel = r_key_sel + 2'd1;
                    n_remain  = r_remain - LENGTH_BITS'(1);
                    if (r_remain == LENGTH_BITS'(1)) begin
                        n_phase = PH_DISCARD;
                    end
                end
                default: begin
                    n_phase = PH_DISCARD;
                end
            endcase
            // end of buffer: drop back to the reset state after this word
            if (i_word.buffer_end) begin
                n_phase    = PH_IDLE;
                n_hcnt     = 3'd0;
                n_remain   = '0;
                n_key_sel  = 2'd0;
                n_mask_key = 32'd0;
                n_binary   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_hcnt     <= 3'd0;
            r_remain   <= '0;
            r_key_sel  <= 2'd0;
            r_mask_key <= 32'd0;
            r_binary   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hcnt     <= n_hcnt;
            r_remain   <= n_remain;
            r_key_sel  <= n_key_sel;
            r_mask_key <= n_mask_key;
            r_binary   <= n_binary;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_word.buffer_end) |=> (r_phase == PH_IDLE && r_remain == '0))
        else $error("parser not cleared after buffer end");

    a_last_leaves_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.word.frame_last) |=>
            (r_phase == PH_DISCARD || r_phase == PH_IDLE))
        else $error("payload phase kept after last byte");

    a_payload_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_remain != '0))
        else $error("payload phase with no bytes left");

    a_idle_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_hcnt == 3'd0 && r_key_sel == 2'd0))
        else $error("counters not clear in idle");
`endif

endmodule : wsu_parser

`default_nettype wire

[src/wsu_out_reg.sv]
`default_nettype none

module wsu_out_reg
    import wsu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_result i_res,
    input  wire logic    i_take,
    output logic         o_space,
    output logic         o_valid,
    output t_out_word    o_word
);

    logic      r_valid, n_valid;
    t_out_word r_word;

    // room when empty or the held word leaves this cycle
    assign o_space = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_valid = r_valid;
        if (i_res.valid) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_word <= i_res.word;
        end
    end

endmodule : wsu_out_reg

`default_nettype wire

[src/websocket_frame_unmasker_core.sv]
// Channel | Valid       | Ready       | Word
// --------+-------------+-------------+--------------------------------------
// in      | i_in_valid  | o_in_ready  | i_in_data  (rx_byte, buffer_end)
// out     | o_out_valid | i_out_ready | o_out_data (payload_byte, is_binary,
//         |             |             |             frame_last)
//
// One word per cycle sustained while the output is not stalled; an accepted payload byte
// passes input register, unmask, result register in turn; header bytes give no word.
// The rate is set by the header/payload update in the parser.
// Reset is synchronous, active low, and returns the parser to header wait.
// A stalled output holds its word; the input register still takes one more.
`default_nettype none

module websocket_frame_unmasker_core
    import wsu_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_data
);

    // Input register: hold one received word until the parser takes it
    logic     r_in_valid, n_in_valid;
    t_in_word r_in_word;

    logic    out_space;
    logic    advance;
    t_result res;

    // Advance the parser whenever a word is held and the result slot has room;
    // header words advance too, as they leave nothing for the result slot.
    assign advance    = r_in_valid && out_space;
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Payload of the input register needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_data;
        end
    end

    // Header phase, length, key and unmask logic
    wsu_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_word  (r_in_word),
        .o_res   (res)
    );

    // Result register toward the consumer
    wsu_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_take  (i_out_ready),
        .o_space (out_space),
        .o_valid (o_out_valid),
        .o_word  (o_out_data)
    );

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_word)))
        else $error("stalled input word lost or changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result word lost or changed");

    a_result_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> (advance && out_space))
        else $error("result produced without room");
`endif

endmodule : websocket_frame_unmasker_core

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;
    import wsu_pkg::*;

    // Run length and timeout
    localparam int unsigned BYTE_TARGET  = 1550;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned REPORT_LIMIT = 100;

    // Receiver stall modes
    localparam int unsigned RX_FREE     = 0;
    localparam int unsigned RX_COIN     = 1;
    localparam int unsigned RX_SLOW     = 2;
    localparam int unsigned RX_PERIODIC = 3;

    typedef struct {
        t_in_word w;
        bit       hold;   // wait until every unmasked byte has drained first
    } t_pending;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_data;

    // Words waiting to be sent, and unmasked bytes still owed by the block
    t_pending  byte_q[$];
    t_out_word unmasked_q[$];

    // Own copy of the parser state
    t_phase                     ps_phase;
    logic [2:0]                 ps_hdr_cnt;
    logic [LENGTH_BITS_DEF-1:0] ps_len;
    logic [LENGTH_BITS_DEF-1:0] ps_idx;
    logic [31:0]                ps_key;
    logic                       ps_bin;

    // Handshake bookkeeping; in_acc is shared between the monitor and the driver
    bit          in_acc;
    int unsigned gap_left, burst_left;
    int unsigned stall_mode, stall_cnt;

    int unsigned fails, cycles, buffers, sent, checked, closed;

    websocket_frame_unmasker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    // Return the parser to header wait, as reset and a buffer end both do
    function automatic void clear_parser_model();
        ps_phase   = PH_IDLE;
        ps_hdr_cnt = '0;
        ps_len     = '0;
        ps_idx     = '0;
        ps_key     = '0;
        ps_bin     = 1'b0;
    endfunction

    // Advance the model by one received byte; flag a result when it unmasks one
    function automatic void unmask_byte(input t_in_word w, output bit got,
                                        output t_out_word r);
        logic [6:0] code;
        logic [7:0] key_byte;
        logic       last;
        got  = 1'b0;
        r    = '0;
        code = w.rx_byte[6:0];
        case (ps_phase)
            PH_IDLE: begin
                // only final text or binary frames get past the first byte
                if (w.rx_byte == HDR_TEXT || w.rx_byte == HDR_BINARY) begin
                    ps_bin   = (w.rx_byte == HDR_BINARY);
                    ps_phase = PH_LEN;
                end else begin
                    ps_phase = PH_DISCARD;
                end
            end
            PH_LEN: begin
                // mask bit ignored: a key is always read
                ps_hdr_cnt = '0;
                ps_key     = '0;
                ps_idx     = '0;
                if (code == LEN_CODE_EXT16) begin
                    ps_len   = '0;
                    ps_phase = PH_EXT16;
                end else if (code == LEN_CODE_EXT64) begin
                    ps_len   = '0;
                    ps_phase = PH_EXT64;
                end else begin
                    ps_len   = LENGTH_BITS_DEF'(code);
                    ps_phase = PH_MASK;
                end
            end
            PH_EXT16, PH_EXT64: begin
                // shifting keeps only the low bits of a 64-bit length
                ps_len = (ps_len << 8) | LENGTH_BITS_DEF'(w.rx_byte);
                if (ps_hdr_cnt == ((ps_phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
                    ps_hdr_cnt = '0;
                    ps_phase   = PH_MASK;
                end else begin
                    ps_hdr_cnt = ps_hdr_cnt + 3'd1;
                end
            end
            PH_MASK: begin
                ps_key = {ps_key[23:0], w.rx_byte};
                if (ps_hdr_cnt == MASK_LAST) begin
                    ps_hdr_cnt = '0;
                    ps_idx     = '0;
                    ps_phase   = (ps_len == '0) ? PH_DISCARD : PH_PAYLOAD;
                end else begin
                    ps_hdr_cnt = ps_hdr_cnt + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                key_byte       = ps_key[8 * (3 - ps_idx[1:0]) +: 8];
                last           = (ps_idx + 1'b1) == ps_len;
                r.payload_byte = w.rx_byte ^ key_byte;
                r.is_binary    = ps_bin;
                r.frame_last   = last;
                got            = 1'b1;
                ps_idx         = ps_idx + 1'b1;
                if (last) begin
                    ps_phase = PH_DISCARD;
                end
            end
            default: begin
                ps_phase = PH_DISCARD;
            end
        endcase
        if (w.buffer_end) begin
            clear_parser_model();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Queue the first cut bytes of a buffer, flagging the buffer end on the last
    task automatic queue_buffer(input logic [7:0] fb[$], input int unsigned cut,
                                input bit hold);
        t_pending p;
        for (int i = 0; i < cut; i++) begin
            p.w.rx_byte    = fb[i];
            p.w.buffer_end = (i == cut - 1);
            p.hold         = hold && (i == 0);
            byte_q.push_back(p);
        end
        buffers++;
    endtask

    // Mostly well-formed frames with random content; some noise, some cut short
    task automatic queue_random_buffer(input bit hold);
        logic [7:0]  fb[$];
        logic [31:0] len;
        int unsigned pick, cut;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
        end else begin
            fb.push_back($urandom_range(0, 1) ? HDR_BINARY : HDR_TEXT);
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 125)
                                                  : $urandom_range(0, 40);
                fb.push_back({1'($urandom), 7'(len)});
            end else if (pick < 85) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(126, 300)
                                                  : $urandom_range(0, 40);
                fb.push_back({1'($urandom), LEN_CODE_EXT16});
                fb.push_back(len[15:8]);
                fb.push_back(len[7:0]);
            end else begin
                // random upper word, which the block must drop
                len = $urandom_range(0, 40);
                fb.push_back({1'($urandom), LEN_CODE_EXT64});
                repeat (4) fb.push_back(8'($urandom));
                for (int i = 3; i >= 0; i--) fb.push_back(len[8 * i +: 8]);
            end
            repeat (4) fb.push_back(8'($urandom));
            repeat (len) fb.push_back(8'($urandom));
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
            end
        end
        cut = fb.size();
        if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, fb.size());
        end
        queue_buffer(fb, cut, hold);
    endtask

    // ------------------------------------------------------------------
    // Driver: send words in bursts, and set the receiver's stall pattern
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        bit free;
        free = !in_valid || in_acc;
        if (i_rst_n && free) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (byte_q.size() > 0 &&
                         !(byte_q[0].hold && unmasked_q.size() > 0)) begin
                in_data  <= byte_q[0].w;
                in_valid <= 1'b1;
                void'(byte_q.pop_front());
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end

        // Pick a new stall mode now and then; free mode gives unbroken stretches
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(RX_FREE, RX_PERIODIC);
            stall_cnt  = $urandom_range(20, 80);
        end else begin
            stall_cnt--;
        end
        case (stall_mode)
            RX_FREE:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= 1'($urandom);
            RX_SLOW:  out_ready <= ($urandom_range(0, 3) == 0);
            default:  out_ready <= (stall_cnt[2:0] != 3'd0);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted byte, check each accepted result
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        bit        got;
        in_acc = 1'b0;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                in_acc = 1'b1;
                sent++;
                unmask_byte(in_data, got, want);
                if (got) begin
                    unmasked_q.push_back(want);
                end
            end
            if (o_out_valid === 1'b1 && out_ready) begin
                if (unmasked_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got %0h",
                             $time, o_out_data);
                end else begin
                    want = unmasked_q.pop_front();
                    checked++;
                    if (want.frame_last) begin
                        closed++;
                    end
                    check_field("payload_byte", want.payload_byte, o_out_data.payload_byte);
                    check_field("is_binary", 8'(want.is_binary), 8'(o_out_data.is_binary));
                    check_field("frame_last", 8'(want.frame_last), 8'(o_out_data.frame_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, unmasked_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the stimulus, release reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] fb[$];
        clear_parser_model();

        // Non-final text frame, then a close frame: both discarded to the end
        fb = '{8'h01, 8'h00};
        queue_buffer(fb, fb.size(), 1'b0);
        fb = '{8'h88};
        queue_buffer(fb, fb.size(), 1'b0);
        // Binary frame, 64-bit length with the upper word all ones, mask bit
        // clear; extreme key bytes, and one byte past the payload
        fb = '{HDR_BINARY, {1'b0, LEN_CODE_EXT64}, 8'hff, 8'hff, 8'hff, 8'hff,
               8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hff, 8'h80, 8'h01,
               8'h3c, 8'hc3, 8'h5a};
        queue_buffer(fb, fb.size(), 1'b0);
        // Empty text payload, buffer ends on the last key byte
        fb = '{HDR_TEXT, 8'h00, 8'haa, 8'h55, 8'h0f, 8'hf0};
        queue_buffer(fb, fb.size(), 1'b0);
        // Masked text frame of one byte, buffer ends on the payload byte
        fb = '{HDR_TEXT, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00};
        queue_buffer(fb, fb.size(), 1'b0);

        // Random buffers; one early on, and about one in fifty at random, wait for the block to drain first
        while (byte_q.size() < BYTE_TARGET) begin
            queue_random_buffer(buffers == 20 || $urandom_range(0, 49) == 0);
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() > 0 || in_valid || unmasked_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (unmasked_q.size() != 0) begin
            fails++;
            $display("%0t: %0d unmasked bytes never arrived", $time, unmasked_q.size());
        end
        $display("sent %0d bytes in %0d buffers, frames cut short and noise included",
                 sent, buffers);
        $display("checked %0d unmasked bytes, %0d of them closing a frame; %0d errors",
                 checked, closed, fails);
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule : testbench

`default_nettype wire
